/* rtl/gfps_pkg.sv */
// Shared constants and types for the grid first-peak scanner.
`timescale 1ns / 1ps
`default_nettype none

package gfps_pkg;

	// Largest grid side and width of one grid value.
	localparam int MAX_DIM    = 128;
	localparam int VALUE_BITS = 16;
	localparam int DIM_BITS   = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;

	// Configuration port.
	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS  = 8;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT    = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = CFG_INDEX_BITS'(1);

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [DIM_BITS-1:0]   dim_t;

	// Control shared by every cell of a line delay chain.
	typedef struct packed {
		logic shift;
		dim_t entry_pos;
	} chain_ctrl_t;

endpackage

`default_nettype wire

/* rtl/grid_first_peak_scan.sv */
// Top level of the streaming grid first-peak scanner.
//
// Grid values enter on the cell channel (cell_valid, cell_stall, cell_value) in
// row-major raster order, one value per request. A cell is a peak when it is
// strictly greater than each of its existing up, down, left and right
// neighbors. On the last cell of a frame one request leaves on the result
// channel (result_valid, result_stall, peak_found, peak_value) carrying the
// first peak in raster order, or zero with peak_found low if there is none.
// Throughput is one cell per clock cycle while cell_stall is low; the result
// is registered when the final cell is accepted. Row and column counts are set
// through the cfg channel (index 0 rows, index 1 columns, clamped to 2..MAX_DIM);
// any accepted write to one of them restarts the frame, and writes to other
// indexes are ignored. After reset both counts are MAX_DIM and the frame
// is at its first cell. The two line stores are delay chains of cells whose
// entry point follows the column count, so a cell is judged when the cell
// below it arrives; their contents are undefined after reset but never read
// before the frame writes them. Results wait in a two-entry output stage, so a
// stalled receiver holds back the cell channel only when both entries are full.
`timescale 1ns / 1ps
`default_nettype none

module grid_first_peak_scan (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// Grid values.
	input  wire                                   cell_valid,
	output logic                                  cell_stall,
	input  wire  [gfps_pkg::VALUE_BITS-1:0]       cell_value,
	// Results.
	output logic                                  result_valid,
	input  wire                                   result_stall,
	output logic                                  peak_found,
	output logic [gfps_pkg::VALUE_BITS-1:0]       peak_value,
	// Configuration writes.
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [gfps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire  [gfps_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	// Turns a written count into its clamped value minus one.
	function automatic gfps_pkg::dim_t clamp_m1(input logic [gfps_pkg::CFG_DATA_BITS-1:0] v);
		gfps_pkg::dim_t res;
		if (int'(v) < 2) begin
			res = gfps_pkg::DIM_BITS'(1);
		end else if (int'(v) > gfps_pkg::MAX_DIM) begin
			res = gfps_pkg::DIM_BITS'(gfps_pkg::MAX_DIM - 1);
		end else begin
			res = gfps_pkg::DIM_BITS'(int'(v) - 1);
		end
		return res;
	endfunction

	// Configuration and raster position.
	gfps_pkg::dim_t   rows_m1_q;
	gfps_pkg::dim_t   cols_m1_q;
	gfps_pkg::dim_t   row_q;
	gfps_pkg::dim_t   col_q;

	// Window: above-left value, last two inputs, and the last-row candidate.
	gfps_pkg::value_t above_left_q;
	gfps_pkg::value_t prev1_q;
	gfps_pkg::value_t prev2_q;
	logic             last_found_q;
	gfps_pkg::value_t last_value_q;

	// First peak found above the last row.
	logic             have_peak_q;
	gfps_pkg::value_t first_peak_q;

	// Two-entry output stage.
	logic             skid_valid_q;
	logic             skid_found_q;
	gfps_pkg::value_t skid_value_q;
	logic             out_found_q;
	gfps_pkg::value_t out_value_q;

	logic                  cell_take;
	logic                  cfg_take;
	logic                  cfg_known;
	gfps_pkg::chain_ctrl_t chain_ctrl;
	gfps_pkg::value_t      mid_tail;
	gfps_pkg::value_t      mid_pre_tail;
	gfps_pkg::value_t      upper_tail;

	logic             overrun;
	gfps_pkg::dim_t   eff_row;
	gfps_pkg::dim_t   eff_col;
	logic             eff_have;
	gfps_pkg::value_t eff_first;
	logic             eff_last_found;
	gfps_pkg::value_t eff_last_value;

	logic             row_ge1;
	logic             row_ge2;
	logic             col_gt0;
	logic             col_ge2;
	logic             col_last;
	logic             row_last;
	logic             frame_end;

	logic             up_ok;
	logic             up_set;
	logic             have_next;
	gfps_pkg::value_t first_next;
	logic             left_ok;
	logic             left_set;
	logic             lr1_found;
	gfps_pkg::value_t lr1_value;
	logic             final_ok;
	logic             final_set;
	logic             lr2_found;
	gfps_pkg::value_t lr2_value;
	logic             res_found;
	gfps_pkg::value_t res_value;
	logic             res_new;
	logic             out_free;

	assign cfg_ready  = 1'b1;
	assign cfg_take   = cfg_valid && cfg_ready;
	assign cfg_known  = (cfg_index == gfps_pkg::REG_ROW_COUNT) ||
		(cfg_index == gfps_pkg::REG_COLUMN_COUNT);
	assign cell_stall = skid_valid_q;
	assign cell_take  = cell_valid && !cell_stall;

	// Both line chains shift on every accepted cell; their length equals the column count.
	assign chain_ctrl = '{shift: cell_take,
		entry_pos: gfps_pkg::DIM_BITS'(gfps_pkg::MAX_DIM - 1) - cols_m1_q};

	// The middle chain holds the previous row, the upper chain the row before it.
	gfps_line u_mid_line (
		.clk           (clk),
		.ctrl          (chain_ctrl),
		.head_data     (cell_value),
		.tail_data     (mid_tail),
		.pre_tail_data (mid_pre_tail)
	);

	gfps_line u_upper_line (
		.clk           (clk),
		.ctrl          (chain_ctrl),
		.head_data     (mid_tail),
		.tail_data     (upper_tail),
		.pre_tail_data ()
	);

	// A position outside the grid restarts the frame at this cell.
	assign overrun        = (row_q > rows_m1_q) || (col_q > cols_m1_q);
	assign eff_row        = overrun ? '0 : row_q;
	assign eff_col        = overrun ? '0 : col_q;
	assign eff_have       = overrun ? 1'b0 : have_peak_q;
	assign eff_first      = overrun ? '0 : first_peak_q;
	assign eff_last_found = overrun ? 1'b0 : last_found_q;
	assign eff_last_value = overrun ? '0 : last_value_q;

	assign row_ge1   = (eff_row != '0);
	assign row_ge2   = (int'(eff_row) >= 2);
	assign col_gt0   = (eff_col != '0);
	assign col_ge2   = (int'(eff_col) >= 2);
	assign col_last  = (eff_col == cols_m1_q);
	assign row_last  = (eff_row == rows_m1_q);
	assign frame_end = row_last && col_last;

	always_comb begin
		// The cell one row up now has all its neighbors.
		up_ok = (mid_tail > cell_value) &&
			(!row_ge2 || (mid_tail > upper_tail)) &&
			(!col_gt0 || (mid_tail > above_left_q)) &&
			(col_last || (mid_tail > mid_pre_tail));
		up_set     = row_ge1 && up_ok && !eff_have;
		have_next  = eff_have || up_set;
		first_next = up_set ? mid_tail : eff_first;

		// In the last row the cell to the left is judged against its own row and the one above.
		left_ok = row_ge1 && row_last && col_gt0 &&
			(prev1_q > cell_value) && (prev1_q > above_left_q) &&
			(!col_ge2 || (prev1_q > prev2_q));
		left_set  = left_ok && !eff_last_found;
		lr1_found = eff_last_found || left_ok;
		lr1_value = left_set ? prev1_q : eff_last_value;

		// The final cell of the frame has only a left and an upper neighbor.
		final_ok = row_ge1 && frame_end &&
			(cell_value > prev1_q) && (cell_value > mid_tail);
		final_set = final_ok && !lr1_found;
		lr2_found = lr1_found || final_ok;
		lr2_value = final_set ? cell_value : lr1_value;

		res_found = have_next || lr2_found;
		if (have_next) begin
			res_value = first_next;
		end else if (lr2_found) begin
			res_value = lr2_value;
		end else begin
			res_value = '0;
		end
	end

	assign res_new  = cell_take && !(cfg_take && cfg_known) && frame_end;
	assign out_free = !result_valid || !result_stall;

	// Window values need no reset: each is written before it is read within a frame.
	always_ff @(posedge clk) begin
		if (cell_take) begin
			above_left_q <= mid_tail;
			prev2_q      <= prev1_q;
			prev1_q      <= cell_value;
		end
	end

	// Frame state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m1_q    <= gfps_pkg::DIM_BITS'(gfps_pkg::MAX_DIM - 1);
			cols_m1_q    <= gfps_pkg::DIM_BITS'(gfps_pkg::MAX_DIM - 1);
			row_q        <= '0;
			col_q        <= '0;
			have_peak_q  <= 1'b0;
			first_peak_q <= '0;
			last_found_q <= 1'b0;
			last_value_q <= '0;
		end else if (cfg_take && cfg_known) begin
			if (cfg_index == gfps_pkg::REG_ROW_COUNT) begin
				rows_m1_q <= clamp_m1(cfg_data);
			end else begin
				cols_m1_q <= clamp_m1(cfg_data);
			end
			row_q        <= '0;
			col_q        <= '0;
			have_peak_q  <= 1'b0;
			first_peak_q <= '0;
			last_found_q <= 1'b0;
			last_value_q <= '0;
		end else if (cell_take) begin
			if (frame_end) begin
				row_q        <= '0;
				col_q        <= '0;
				have_peak_q  <= 1'b0;
				first_peak_q <= '0;
				last_found_q <= 1'b0;
				last_value_q <= '0;
			end else begin
				if (col_last) begin
					col_q <= '0;
					row_q <= eff_row + gfps_pkg::DIM_BITS'(1);
				end else begin
					col_q <= eff_col + gfps_pkg::DIM_BITS'(1);
					row_q <= eff_row;
				end
				have_peak_q  <= have_next;
				first_peak_q <= first_next;
				last_found_q <= lr2_found;
				last_value_q <= lr2_value;
			end
		end
	end

	// Output stage: a result goes to the free output register if the skid entry is empty, else to the skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid <= skid_valid_q || res_new;
			skid_valid_q <= skid_valid_q && res_new;
		end else if (res_new) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_found_q  <= skid_found_q;
				out_value_q  <= skid_value_q;
				skid_found_q <= res_found;
				skid_value_q <= res_value;
			end else begin
				out_found_q <= res_found;
				out_value_q <= res_value;
			end
		end else if (res_new) begin
			skid_found_q <= res_found;
			skid_value_q <= res_value;
		end
	end

	assign peak_found = out_found_q;
	assign peak_value = out_value_q;

endmodule

`default_nettype wire

/* rtl/gfps_cell.sv */
// One storage cell of a line delay chain.
`timescale 1ns / 1ps
`default_nettype none

module gfps_cell (
	input  wire                  clk,
	input  gfps_pkg::chain_ctrl_t ctrl,
	input  gfps_pkg::dim_t        slot,
	input  gfps_pkg::value_t      head_data,
	input  gfps_pkg::value_t      left_data,
	output gfps_pkg::value_t      data
);

	gfps_pkg::value_t data_q;

	// The cell at the entry position takes the new value; the others take their left neighbor.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= (ctrl.entry_pos == slot) ? head_data : left_data;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

/* rtl/gfps_line.sv */
// Line delay chain: a row of cells whose length follows the column count.
`timescale 1ns / 1ps
`default_nettype none

module gfps_line (
	input  wire                   clk,
	input  gfps_pkg::chain_ctrl_t ctrl,
	input  gfps_pkg::value_t      head_data,
	output gfps_pkg::value_t      tail_data,
	output gfps_pkg::value_t      pre_tail_data
);

	gfps_pkg::value_t cell_data [gfps_pkg::MAX_DIM];

	for (genvar i = 0; i < gfps_pkg::MAX_DIM; i++) begin : g_cell
		if (i == 0) begin : g_first
			gfps_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.slot      (gfps_pkg::DIM_BITS'(i)),
				.head_data (head_data),
				.left_data (head_data),
				.data      (cell_data[i])
			);
		end else begin : g_rest
			gfps_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.slot      (gfps_pkg::DIM_BITS'(i)),
				.head_data (head_data),
				.left_data (cell_data[i-1]),
				.data      (cell_data[i])
			);
		end
	end

	// Values entered a full line ago and one item less than that.
	assign tail_data     = cell_data[gfps_pkg::MAX_DIM-1];
	assign pre_tail_data = cell_data[gfps_pkg::MAX_DIM-2];

endmodule

`default_nettype wire

/* rtl/gfps_checker.sv */
// Port-level checks for the grid first-peak scanner, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module gfps_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                cell_valid,
	input wire                                cell_stall,
	input wire                                result_valid,
	input wire                                result_stall,
	input wire                                peak_found,
	input wire [gfps_pkg::VALUE_BITS-1:0]     peak_value
);

	// A held result stays offered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result request dropped while stalled");

	// Without a peak the reported value is zero.
	a_no_peak_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !peak_found |-> peak_value == '0)
		else $error("peak_value nonzero without a peak");

	// The cell channel is held back only while a result is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cell_stall |-> result_valid)
		else $error("cell channel stalled with no pending result");

	// A new result follows an accepted cell.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(cell_valid && !cell_stall))
		else $error("result appeared without an accepted cell");

endmodule

bind grid_first_peak_scan gfps_checker u_gfps_checker (.*);

`default_nettype wire
